@@ rtl/owned_message_fifo_macros.svh @@
// Assertion macros for the owned message FIFO.
`ifndef OWNED_MESSAGE_FIFO_MACROS_SVH
`define OWNED_MESSAGE_FIFO_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge outside reset.
`define OMF_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("owned_message_fifo: invariant violated");

// Antecedent implies consequent in the same cycle.
`define OMF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owned_message_fifo: implication violated");

// Antecedent implies consequent in the next cycle.
`define OMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owned_message_fifo: next-cycle check violated");

`else

`define OMF_ASSERT_ALWAYS(label, clk, rst, cond)
`define OMF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define OMF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/omf_pkg.sv @@
// Types and codes shared by the owned message FIFO.
`timescale 1ns / 1ps

package omf_pkg;

  localparam int MsgW    = 32;
  localparam int TaskW   = 8;
  localparam int FillW   = 5;
  localparam int StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOPERM = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

endpackage

@@ rtl/owned_message_fifo.sv @@
// Message FIFO with an owning task: enqueue from anyone, dequeue by the owner only.
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register, where its result is valid.
// Throughput: 1 item per cycle while the result is not stalled; each item is decided by one pass
// of logic between the input and result registers, which also updates the ring pointers and slot memory.
// Reset (rst, synchronous, active high) clears pointers, count, owner register and valid bits.
// Slot contents are not cleared; the ring only reads slots it wrote, so no clearing pass runs.

`include "owned_message_fifo_macros.svh"

module owned_message_fifo #(
  parameter int DEPTH      = 16,
  parameter int ITEM_BYTES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [omf_pkg::MsgW-1:0]     message_in,
  input  logic [omf_pkg::TaskW-1:0]    task_id,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [omf_pkg::StatusW-1:0]  status,
  output logic [omf_pkg::MsgW-1:0]     message_out,
  output logic [omf_pkg::FillW-1:0]    fill_count,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [omf_pkg::TaskW-1:0]    cfg_data
);

  localparam int ItemW = (ITEM_BYTES >= 4) ? omf_pkg::MsgW : ITEM_BYTES * 8;
  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);

  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

  // slot memory
  logic [ItemW-1:0] slot_store [DEPTH];

  // ring state
  logic [PtrW-1:0] read_slot, read_slot_next;
  logic [PtrW-1:0] write_slot, write_slot_next;
  logic [CntW-1:0] held_count, held_count_next;
  logic [omf_pkg::TaskW-1:0] owner_task;

  // input register
  logic                      s1_valid;
  omf_pkg::action_t          s1_action;
  logic [ItemW-1:0]          s1_msg;
  logic [omf_pkg::TaskW-1:0] s1_task;

  // decision
  logic             advance;
  logic             enq_ok;
  logic             deq_ok;
  omf_pkg::status_t status_next;

  // result register
  omf_pkg::status_t out_status;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;

  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    status_next = omf_pkg::ST_OK;
    case (s1_action)
      omf_pkg::ACT_ENQ: begin
        if (held_count >= FullCnt) begin
          status_next = omf_pkg::ST_FULL;
        end else begin
          enq_ok = 1'b1;
        end
      end
      omf_pkg::ACT_DEQ: begin
        // empty check takes priority over the owner check
        if (held_count == '0) begin
          status_next = omf_pkg::ST_EMPTY;
        end else if (s1_task != owner_task) begin
          status_next = omf_pkg::ST_NOPERM;
        end else begin
          deq_ok = 1'b1;
        end
      end
      default: begin
        status_next = omf_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    read_slot_next  = read_slot;
    write_slot_next = write_slot;
    held_count_next = held_count;
    if (enq_ok) begin
      write_slot_next = (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
      held_count_next = held_count + 1'b1;
    end
    if (deq_ok) begin
      read_slot_next  = (read_slot == LastSlot) ? '0 : read_slot + 1'b1;
      held_count_next = held_count - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      read_slot  <= '0;
      write_slot <= '0;
      held_count <= '0;
      owner_task <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        owner_task <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        read_slot  <= read_slot_next;
        write_slot <= write_slot_next;
        held_count <= held_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= omf_pkg::action_t'(action);
      s1_msg    <= message_in[ItemW-1:0];
      s1_task   <= task_id;
    end
  end

  // slot memory write
  always_ff @(posedge clk) begin
    if (advance && enq_ok) begin
      slot_store[write_slot] <= s1_msg;
    end
  end

  // result register payload; the slot read lands here directly
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      fill_count <= omf_pkg::FillW'(held_count_next);
      if (deq_ok) begin
        message_out <= omf_pkg::MsgW'(slot_store[read_slot]);
      end else begin
        message_out <= '0;
      end
    end
  end

  assign status = out_status;

  `OMF_ASSERT_ALWAYS(a_count_bound, clk, rst, held_count <= FullCnt)
  `OMF_ASSERT_IMPLIES(a_empty_ptrs, clk, rst, held_count == '0, read_slot == write_slot)
  `OMF_ASSERT_IMPLIES(a_fail_zero, clk, rst, out_valid && out_status != omf_pkg::ST_OK, message_out == '0)
  `OMF_ASSERT_NEXT(a_hold_s1, clk, rst, s1_valid && out_valid && out_stall, s1_valid)

endmodule
